FILE: rtl/vaca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaca_pkg: shared types and codes for the variable adjust chain ALU
// Payload structs, operation and size codes, sequencer states and the
// operand-size helpers used by the datapath.
// ----------------------------------------------------------------------------
package vaca_pkg;

    typedef enum logic [1:0] {
        ADJ_NONE = 2'd0,
        ADJ_DIV  = 2'd1,
        ADJ_MOD  = 2'd2,
        ADJ_ADD  = 2'd3
    } adjust_kind_t;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_SMIN  = 4'd2,
        OP_SMAX  = 4'd3,
        OP_UMIN  = 4'd4,
        OP_UMAX  = 4'd5,
        OP_SDIV  = 4'd6,
        OP_SMOD  = 4'd7,
        OP_UDIV  = 4'd8,
        OP_UMOD  = 4'd9,
        OP_MUL   = 4'd10,
        OP_AND   = 4'd11,
        OP_OR    = 4'd12,
        OP_XOR   = 4'd13,
        OP_PASS  = 4'd14,
        OP_PASS2 = 4'd15
    } alu_op_t;

    typedef enum logic [1:0] {
        SZ_BYTE  = 2'd0,
        SZ_WORD  = 2'd1,
        SZ_DWORD = 2'd2,
        SZ_WIDE  = 2'd3
    } operand_size_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_ADJ_ADD,
        ST_ADJ_SETUP,
        ST_DIV_RUN,
        ST_DIV_FIX,
        ST_ALU_SETUP,
        ST_DONE
    } state_t;

    localparam int unsigned DataWidth  = 32;
    localparam int unsigned StepWidth  = $clog2(DataWidth);
    localparam int unsigned ShiftDigit = 4;

    typedef struct packed {
        logic [31:0] variable_value;
        logic [4:0]  shift_count;
        logic [31:0] value_mask;
        logic [31:0] add_value;
        logic [31:0] divmod_value;
        logic [1:0]  adjust_kind;
        logic [3:0]  operation;
        logic [1:0]  operand_size;
        logic        chain_start;
        logic [31:0] start_value;
    } vaca_in_t;

    typedef struct packed {
        logic [31:0] result;
        logic        divide_by_zero;
    } vaca_out_t;

    // Low-bit mask for the operand size; size three acts as dword.
    function automatic logic [31:0] size_mask(input logic [1:0] size);
        logic [31:0] m;
        case (size)
            SZ_BYTE: m = 32'h0000_00FF;
            SZ_WORD: m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Sign-extend the low operand-size bits to 32 bits.
    function automatic logic [31:0] sext_size(input logic [31:0] v, input logic [1:0] size);
        logic [31:0] s;
        case (size)
            SZ_BYTE: s = {{24{v[7]}}, v[7:0]};
            SZ_WORD: s = {{16{v[15]}}, v[15:0]};
            default: s = v;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/variable_adjust_chain_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_adjust_chain_alu: one adjust-and-combine step per item
// Shifts, masks, offsets and optionally divides or takes a modulo of a value,
// then folds it into a running accumulator, using a serial divide/multiply unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one step (vaca_in_t). A transfer happens on a
//   rising edge with both high. in_ready is high whenever the sequencer is
//   idle, even while the last result still sits in the output register.
//   out_valid/out_ready carry one result (vaca_out_t) per step: the new
//   accumulator, zero-extended from the operand size, and a divide-by-zero
//   flag.
//   Each step goes through the shift, the offset, the adjust setup and
//   divide or modulo when the adjust divides or takes a modulo (the divide
//   runs only with a nonzero divisor), ALU setup, the ALU multiply or its
//   divide or modulo with a nonzero divisor, and the output load. The 32-step
//   shared radix-2 divide/multiply unit is used at most twice per step. One
//   item is in flight; the next transfer can come once the sequencer is back
//   in idle after the result loads.
//   Reset clears the accumulator to zero and drops any pending result.
//   A stalled receiver holds the result in the output register; the block
//   finishes the next step and waits in its last state until the register
//   frees up.
// ----------------------------------------------------------------------------
module variable_adjust_chain_alu
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vaca_pkg::vaca_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vaca_pkg::vaca_out_t out_data
);
    import vaca_pkg::*;

    state_t          state_reg, state_next;
    vaca_in_t        item_reg;
    logic [31:0]     acc_reg;
    logic [31:0]     v_reg;        // value under adjustment
    logic [4:0]      cnt_reg;      // remaining shift distance
    logic [31:0]     dvd_reg;      // dividend / quotient, or multiplier
    logic [31:0]     rem_reg;      // partial remainder, or product
    logic [31:0]     dvs_reg;      // divisor, or shifted multiplicand
    logic [StepWidth-1:0] step_reg;
    logic            mul_mode_reg;
    logic            want_rem_reg;
    logic            neg_reg;
    logic            alu_phase_reg;
    logic            dz_reg;
    logic [31:0]     r_reg;
    logic            out_valid_reg;
    vaca_out_t       out_data_reg;

    logic            accept;
    logic            out_free;
    logic [31:0]     mask;
    logic [31:0]     a_val, b_val, a_sx, b_sx;
    logic [31:0]     num, den, num_mag, den_mag;
    logic            num_s, den_s, ld_want_rem, ld_neg;
    logic            alu_is_div, alu_is_mul;
    logic [31:0]     alu_simple;
    logic [32:0]     trial;
    logic            trial_ge;
    logic [32:0]     trial_diff;
    logic [31:0]     fix_mag, fix_val;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Operand preparation for the shared divide/multiply unit and the ALU.
    always_comb
    begin
        mask        = size_mask(item_reg.operand_size);
        a_val       = acc_reg & mask;
        b_val       = v_reg & mask;
        a_sx        = sext_size(a_val, item_reg.operand_size);
        b_sx        = sext_size(b_val, item_reg.operand_size);
        alu_is_div  = item_reg.operation inside {OP_SDIV, OP_SMOD, OP_UDIV, OP_UMOD};
        alu_is_mul  = (item_reg.operation == OP_MUL);
        num         = v_reg;
        num_s       = 1'b0;
        den         = 32'd0;
        den_s       = 1'b0;
        ld_want_rem = 1'b0;
        if (state_reg == ST_ADJ_SETUP)
        begin
            if (item_reg.adjust_kind == ADJ_DIV)
            begin
                num   = v_reg;
                num_s = v_reg[31];
                den   = sext_size(item_reg.divmod_value, item_reg.operand_size);
                den_s = den[31];
            end
            else
            begin
                // Dword modulo is unsigned; narrower sizes keep the signed dividend.
                num         = v_reg;
                num_s       = !(item_reg.operand_size inside {SZ_DWORD, SZ_WIDE}) && v_reg[31];
                den         = item_reg.divmod_value & mask;
                ld_want_rem = 1'b1;
            end
        end
        else
        begin
            if (item_reg.operation inside {OP_SDIV, OP_SMOD})
            begin
                num   = a_sx;
                num_s = a_sx[31];
                den   = b_sx;
                den_s = b_sx[31];
            end
            else
            begin
                num = a_val;
                den = b_val;
            end
            ld_want_rem = item_reg.operation inside {OP_SMOD, OP_UMOD};
        end
        num_mag = num_s ? (32'd0 - num) : num;
        den_mag = den_s ? (32'd0 - den) : den;
        ld_neg  = ld_want_rem ? num_s : (num_s ^ den_s);
    end

    // Combinational ALU operations.
    always_comb
    begin
        case (item_reg.operation)
            OP_ADD:  alu_simple = a_val + b_val;
            OP_SUB:  alu_simple = a_val - b_val;
            OP_SMIN: alu_simple = ($signed(a_sx) < $signed(b_sx)) ? a_val : b_val;
            OP_SMAX: alu_simple = ($signed(a_sx) > $signed(b_sx)) ? a_val : b_val;
            OP_UMIN: alu_simple = (a_val < b_val) ? a_val : b_val;
            OP_UMAX: alu_simple = (a_val > b_val) ? a_val : b_val;
            OP_AND:  alu_simple = a_val & b_val;
            OP_OR:   alu_simple = a_val | b_val;
            OP_XOR:  alu_simple = a_val ^ b_val;
            default: alu_simple = b_val;
        endcase
    end

    // One restoring-division step, and the sign fix at the end.
    always_comb
    begin
        trial      = {rem_reg, dvd_reg[31]};
        trial_ge   = (trial >= {1'b0, dvs_reg});
        trial_diff = trial - {1'b0, dvs_reg};
        fix_mag    = want_rem_reg ? rem_reg : dvd_reg;
        fix_val    = neg_reg ? (32'd0 - fix_mag) : fix_mag;
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_ADJ_ADD;
                end
            end
            ST_ADJ_ADD:
            begin
                if (item_reg.adjust_kind inside {ADJ_DIV, ADJ_MOD})
                begin
                    state_next = ST_ADJ_SETUP;
                end
                else
                begin
                    state_next = ST_ALU_SETUP;
                end
            end
            ST_ADJ_SETUP:
            begin
                state_next = (den == 32'd0) ? ST_ALU_SETUP : ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_DIV_FIX;
                end
            end
            ST_DIV_FIX:
            begin
                state_next = alu_phase_reg ? ST_DONE : ST_ALU_SETUP;
            end
            ST_ALU_SETUP:
            begin
                if (alu_is_mul || (alu_is_div && den != 32'd0))
                begin
                    state_next = ST_DIV_RUN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Accumulator and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && in_data.chain_start)
            begin
                acc_reg <= in_data.start_value;
            end
            else if (state_reg == ST_DONE && out_free)
            begin
                acc_reg <= r_reg & mask;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg.result         <= r_reg & mask;
            out_data_reg.divide_by_zero <= dz_reg;
        end
    end

    // Datapath: payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_reg <= in_data;
                    v_reg    <= in_data.variable_value;
                    cnt_reg  <= in_data.shift_count;
                    dz_reg   <= 1'b0;
                end
            end
            ST_SHIFT:
            begin
                // Arithmetic shift, one digit per cycle, then one bit at a time, then the value mask.
                if (cnt_reg == 5'd0)
                begin
                    v_reg <= v_reg & item_reg.value_mask;
                end
                else if (cnt_reg >= 5'(ShiftDigit))
                begin
                    v_reg   <= {{ShiftDigit{v_reg[31]}}, v_reg[31:ShiftDigit]};
                    cnt_reg <= cnt_reg - 5'(ShiftDigit);
                end
                else
                begin
                    v_reg   <= {v_reg[31], v_reg[31:1]};
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
            ST_ADJ_ADD:
            begin
                if (item_reg.adjust_kind != ADJ_NONE)
                begin
                    v_reg <= v_reg + sext_size(item_reg.add_value, item_reg.operand_size);
                end
            end
            ST_ADJ_SETUP:
            begin
                if (den == 32'd0)
                begin
                    v_reg  <= 32'd0;
                    dz_reg <= 1'b1;
                end
                else
                begin
                    dvd_reg       <= num_mag;
                    dvs_reg       <= den_mag;
                    rem_reg       <= 32'd0;
                    step_reg      <= StepWidth'(DataWidth - 1);
                    mul_mode_reg  <= 1'b0;
                    want_rem_reg  <= ld_want_rem;
                    neg_reg       <= ld_neg;
                    alu_phase_reg <= 1'b0;
                end
            end
            ST_DIV_RUN:
            begin
                step_reg <= step_reg - StepWidth'(1);
                if (mul_mode_reg)
                begin
                    // Shift-add: one multiplier bit per cycle.
                    if (dvd_reg[0])
                    begin
                        rem_reg <= rem_reg + dvs_reg;
                    end
                    dvs_reg <= {dvs_reg[30:0], 1'b0};
                    dvd_reg <= {1'b0, dvd_reg[31:1]};
                end
                else
                begin
                    rem_reg <= trial_ge ? trial_diff[31:0] : trial[31:0];
                    dvd_reg <= {dvd_reg[30:0], trial_ge};
                end
            end
            ST_DIV_FIX:
            begin
                if (alu_phase_reg)
                begin
                    r_reg <= fix_val;
                end
                else
                begin
                    v_reg <= fix_val;
                end
            end
            ST_ALU_SETUP:
            begin
                alu_phase_reg <= 1'b1;
                step_reg      <= StepWidth'(DataWidth - 1);
                rem_reg       <= 32'd0;
                if (alu_is_mul)
                begin
                    dvd_reg      <= b_val;
                    dvs_reg      <= a_val;
                    mul_mode_reg <= 1'b1;
                    want_rem_reg <= 1'b1;
                    neg_reg      <= 1'b0;
                end
                else if (alu_is_div)
                begin
                    if (den == 32'd0)
                    begin
                        r_reg  <= 32'd0;
                        dz_reg <= 1'b1;
                    end
                    else
                    begin
                        dvd_reg      <= num_mag;
                        dvs_reg      <= den_mag;
                        mul_mode_reg <= 1'b0;
                        want_rem_reg <= ld_want_rem;
                        neg_reg      <= ld_neg;
                    end
                end
                else
                begin
                    r_reg <= alu_simple;
                end
            end
            default:
            begin
            end
        endcase
    end

    // A result appears only out of the final state.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the final state");

    // Restoring division keeps the partial remainder below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_RUN && !mul_mode_reg) |-> (rem_reg < dvs_reg))
        else $error("partial remainder not below divisor");

    // Division never starts with a zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_RUN && !mul_mode_reg) |-> (dvs_reg != 32'd0))
        else $error("divider running on zero divisor");

    // Accumulator moves only on a chain start or when a result is loaded.
    a_acc_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(acc_reg) |->
            $past((accept && in_data.chain_start) || (state_reg == ST_DONE && out_free)))
        else $error("accumulator changed outside a transfer");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the variable adjust chain ALU
// Drives adjustment steps over the in_valid/in_ready channel and checks every
// result transfer against an in-bench model of the shift, mask, adjust and
// ALU stages and of the running accumulator. Flow control runs through three
// phases, two with random idling and one free running, with a full drain between phases.
// ----------------------------------------------------------------------------
module tb_top;

    import vaca_pkg::*;

    localparam int unsigned RandomPerPhase = 460;
    localparam int unsigned SettleCycles   = 100;
    localparam int unsigned CycleLimit     = 1_500_000;
    localparam int unsigned ReportLimit    = 10;

    // ------------------------------------------------------------------------
    // Accumulator model and store of expected results
    // ------------------------------------------------------------------------
    class chain_scoreboard;
        logic [31:0] acc;
        vaca_out_t   pending_results[$];
        int unsigned steps;
        int unsigned results;
        int unsigned dz_seen;
        int unsigned mismatches;

        function new();
            acc        = '0;
            steps      = 0;
            results    = 0;
            dz_seen    = 0;
            mismatches = 0;
        endfunction

        // Two's complement value of the low operand-size bits.
        function longint as_signed(logic [31:0] x, logic [1:0] size);
            case (operand_size_t'(size))
                SZ_BYTE: return longint'($signed(x[7:0]));
                SZ_WORD: return longint'($signed(x[15:0]));
                default: return longint'($signed(x));
            endcase
        endfunction

        function vaca_out_t predict_step(vaca_in_t s);
            logic [31:0] size_bits;
            logic [31:0] v;
            logic [31:0] d;
            logic [31:0] lhs;
            logic [31:0] rhs;
            logic [31:0] r;
            longint      dv;
            longint      lhs_s;
            longint      rhs_s;
            logic        dz;
            vaca_out_t   o;

            if (s.chain_start)
                acc = s.start_value;
            case (operand_size_t'(s.operand_size))
                SZ_BYTE: size_bits = 32'h0000_00FF;
                SZ_WORD: size_bits = 32'h0000_FFFF;
                default: size_bits = 32'hFFFF_FFFF;
            endcase
            dz = 1'b0;

            v = $signed(s.variable_value) >>> s.shift_count;
            v = v & s.value_mask;

            if (s.adjust_kind != ADJ_NONE) begin
                v = v + 32'(as_signed(s.add_value, s.operand_size));
                if (s.adjust_kind == ADJ_DIV) begin
                    dv = as_signed(s.divmod_value, s.operand_size);
                    if (dv == 0) begin
                        v  = '0;
                        dz = 1'b1;
                    end
                    else
                        v = 32'(longint'($signed(v)) / dv);
                end
                else if (s.adjust_kind == ADJ_MOD) begin
                    d = s.divmod_value & size_bits;
                    if (d == 0) begin
                        v  = '0;
                        dz = 1'b1;
                    end
                    else if (size_bits == 32'hFFFF_FFFF)
                        v = v % d;
                    else
                        v = 32'(longint'($signed(v)) % longint'(d));
                end
            end

            rhs   = v & size_bits;
            lhs   = acc & size_bits;
            lhs_s = as_signed(lhs, s.operand_size);
            rhs_s = as_signed(rhs, s.operand_size);

            case (alu_op_t'(s.operation))
                OP_ADD:  r = lhs + rhs;
                OP_SUB:  r = lhs - rhs;
                OP_SMIN: r = (lhs_s < rhs_s) ? lhs : rhs;
                OP_SMAX: r = (lhs_s > rhs_s) ? lhs : rhs;
                OP_UMIN: r = (lhs < rhs) ? lhs : rhs;
                OP_UMAX: r = (lhs > rhs) ? lhs : rhs;
                OP_SDIV, OP_SMOD:
                begin
                    if (rhs == 0) begin
                        r  = '0;
                        dz = 1'b1;
                    end
                    else if (s.operation == OP_SMOD)
                        r = 32'(lhs_s % rhs_s);
                    else
                        r = 32'(lhs_s / rhs_s);
                end
                OP_UDIV, OP_UMOD:
                begin
                    if (rhs == 0) begin
                        r  = '0;
                        dz = 1'b1;
                    end
                    else if (s.operation == OP_UMOD)
                        r = lhs % rhs;
                    else
                        r = lhs / rhs;
                end
                OP_MUL:  r = lhs * rhs;
                OP_AND:  r = lhs & rhs;
                OP_OR:   r = lhs | rhs;
                OP_XOR:  r = lhs ^ rhs;
                default: r = rhs;
            endcase

            acc              = r & size_bits;
            o.result         = acc;
            o.divide_by_zero = dz;
            return o;
        endfunction

        function void note_step(vaca_in_t s);
            steps++;
            pending_results.push_back(predict_step(s));
        endfunction

        function void check_result(vaca_out_t got);
            vaca_out_t want;
            results++;
            if (got.divide_by_zero)
                dz_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= ReportLimit)
                    $display("%0t: result %h dz %b with no step outstanding",
                             $time, got.result, got.divide_by_zero);
                return;
            end
            want = pending_results.pop_front();
            if (got.result !== want.result || got.divide_by_zero !== want.divide_by_zero) begin
                mismatches++;
                if (mismatches <= ReportLimit)
                    $display("%0t: result #%0d: result exp %h got %h, dz exp %b got %b",
                             $time, results, want.result, got.result,
                             want.divide_by_zero, got.divide_by_zero);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    vaca_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    vaca_out_t out_data;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned cycle_count = 0;

    chain_scoreboard sb = new();

    always #2 clk = ~clk;

    variable_adjust_chain_alu dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------------
    // Monitors: these run at the edge and see the values that the block
    // sampled, since every bench drive is nonblocking.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (in_valid && in_ready)
                sb.note_step(in_data);
        end
    end

    // Receiver: stall at random at the current rate; a rate of zero never stalls.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rx_idle_pct);

    // Watchdog: end a hung run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_results.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic vaca_in_t make_step(logic [31:0] value, logic [4:0] sh,
                                           logic [31:0] mask, logic [31:0] offset,
                                           logic [31:0] divisor, adjust_kind_t kind,
                                           alu_op_t op, operand_size_t size,
                                           logic restart, logic [31:0] seed_acc);
        vaca_in_t s;
        s.variable_value = value;
        s.shift_count    = sh;
        s.value_mask     = mask;
        s.add_value      = offset;
        s.divmod_value   = divisor;
        s.adjust_kind    = kind;
        s.operation      = op;
        s.operand_size   = size;
        s.chain_start    = restart;
        s.start_value    = seed_acc;
        return s;
    endfunction

    // Favor the corner values of a 32-bit word, then fully random.
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(7))
            0:       w = 32'h0000_0000;
            1:       w = 32'hFFFF_FFFF;
            2:       w = 32'h8000_0000;
            3:       w = 32'h7FFF_FFFF;
            4:       w = 32'($urandom_range(255));
            5:       w = 32'h0 - 32'($urandom_range(1, 255));
            default: w = $urandom();
        endcase
        return w;
    endfunction

    function automatic vaca_in_t random_step();
        vaca_in_t s;
        s.variable_value = pick_word();
        s.shift_count    = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom_range(31));
        s.value_mask     = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF : pick_word();
        s.add_value      = pick_word();
        // Zero, minus one and small divisors hit the divide corners often.
        case ($urandom_range(7))
            0:       s.divmod_value = 32'h0000_0000;
            1:       s.divmod_value = 32'hFFFF_FFFF;
            2, 3:    s.divmod_value = 32'($urandom_range(1, 20));
            4:       s.divmod_value = 32'hFFFF_FF00 | 32'($urandom_range(255));
            default: s.divmod_value = $urandom();
        endcase
        s.adjust_kind    = 2'($urandom_range(3));
        s.operation      = 4'($urandom_range(15));
        s.operand_size   = 2'($urandom_range(3));
        s.chain_start    = ($urandom_range(5) == 0);
        s.start_value    = pick_word();
        return s;
    endfunction

    // Present one step and hold it until the transfer. Valid is not lowered
    // between back-to-back steps; it drops only while the sender idles.
    task automatic send_step(input vaca_in_t s);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and hold off until every expected result has arrived.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_results.size() != 0);
    endtask

    // Extremes of each field, every operation, and the named corner cases.
    task automatic run_directed();
        // Clear the chain with a plain add of zero.
        send_step(make_step(32'h0, 5'd0, 32'hFFFF_FFFF, 32'h0, 32'h0,
                            ADJ_NONE, OP_ADD, SZ_DWORD, 1'b1, 32'h0));
        // Walk all sixteen operations across kinds, sizes and shifts.
        for (int i = 0; i < 16; i++)
            send_step(make_step(32'hC3A5_0F96 + 32'(i) * 32'h0101_0101, 5'(i * 2),
                                32'hFFFF_FFFF, 32'h10 + 32'(i), 32'h3,
                                adjust_kind_t'(i % 4), alu_op_t'(i),
                                operand_size_t'(i % 4), (i % 5) == 0, 32'h8765_4321));
        // Adjust divide by zero.
        send_step(make_step(32'h1234, 5'd0, 32'hFFFF_FFFF, 32'h5, 32'h0,
                            ADJ_DIV, OP_ADD, SZ_WORD, 1'b0, 32'h0));
        // Adjust modulo whose divisor is zero once cut to a byte.
        send_step(make_step(32'h55, 5'd0, 32'hFFFF_FFFF, 32'h1, 32'h100,
                            ADJ_MOD, OP_XOR, SZ_BYTE, 1'b0, 32'h0));
        // Most negative dword divided by minus one in the adjust stage.
        send_step(make_step(32'h8000_0000, 5'd0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                            ADJ_DIV, OP_PASS, SZ_DWORD, 1'b0, 32'h0));
        // Most negative accumulator divided by minus one in the ALU, as a dword quotient and a byte remainder.
        send_step(make_step(32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF, 32'h0, 32'h0,
                            ADJ_NONE, OP_SDIV, SZ_DWORD, 1'b1, 32'h8000_0000));
        send_step(make_step(32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF, 32'h0, 32'h0,
                            ADJ_NONE, OP_SMOD, SZ_BYTE, 1'b1, 32'h0000_0080));
        // ALU zero divisors.
        send_step(make_step(32'h0, 5'd0, 32'hFFFF_FFFF, 32'h0, 32'h0,
                            ADJ_NONE, OP_UDIV, SZ_DWORD, 1'b1, 32'h5));
        send_step(make_step(32'hFFFF_FFFF, 5'd31, 32'h0, 32'h0, 32'h0,
                            ADJ_NONE, OP_SMOD, SZ_WIDE, 1'b1, 32'h7));
        // Full shift of a negative value, then offset only.
        send_step(make_step(32'h8000_0000, 5'd31, 32'hFFFF_FFFF, 32'h1, 32'h0,
                            ADJ_ADD, OP_SMIN, SZ_WORD, 1'b1, 32'hFFFF_8000));
        // Negative dividend modulo at word size, then unsigned at dword size.
        send_step(make_step(32'hFFFF_FFF9, 5'd0, 32'hFFFF_FFFF, 32'h0, 32'h3,
                            ADJ_MOD, OP_SMAX, SZ_WORD, 1'b0, 32'h0));
        send_step(make_step(32'hFFFF_FFF9, 5'd0, 32'hFFFF_FFFF, 32'h0, 32'hA,
                            ADJ_MOD, OP_UMAX, SZ_DWORD, 1'b0, 32'h0));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++) begin
            // Sender 28 / receiver 85, then swapped, then free running.
            case (phase)
                0:
                begin
                    tx_idle_pct = 28;
                    rx_idle_pct = 85;
                end
                1:
                begin
                    tx_idle_pct = 85;
                    rx_idle_pct = 28;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (phase == 0) begin
                run_directed();
                hold_until_drained();
            end
            repeat (RandomPerPhase)
                send_step(random_step());
            hold_until_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (SettleCycles) @(posedge clk);

        $display("ran %0d steps through three flow-control phases in %0d cycles",
                 sb.steps, cycle_count);
        $display("checked %0d results, %0d flagged divide-by-zero, %0d mismatches",
                 sb.results, sb.dz_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
